[hw/rtl/rpb_pkg.sv]
// Shared types and constants for the RGB pixel blend unit.
// No dependencies; every other file imports this package.
package rpb_pkg;

   localparam int PIX_W          = 8;
   localparam int GAIN_W         = 16;
   localparam int GAIN_FRAC_BITS = 8;
   localparam int CSR_INDEX_W    = 8;
   localparam int CSR_DATA_W     = 16;

   // Lane datapath widths
   localparam int PROD_W     = PIX_W + GAIN_W;      // full multiplier output
   localparam int SUM_W      = PROD_W + 1;          // product plus rounding half
   localparam int QIN_W      = 17;                  // largest quotient dividend
   localparam int DIVM_W     = QIN_W + 1;           // dividend plus 127
   localparam int QEST_W     = DIVM_W - PIX_W;      // estimated quotient
   localparam int SCALE_HALF = 1 << (GAIN_FRAC_BITS - 1);

   typedef enum logic [2:0] {
      MODE_MULTIPLY = 3'd0,
      MODE_SCREEN   = 3'd1,
      MODE_OVERLAY  = 3'd2,
      MODE_SUBTRACT = 3'd3,
      MODE_ADD      = 3'd4,
      MODE_SCALE    = 3'd5
   } blend_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLEND_MODE = 8'd0,
      CSR_GAIN_RED   = 8'd1,
      CSR_GAIN_GREEN = 8'd2,
      CSR_GAIN_BLUE  = 8'd3
   } csr_index_type;

   // How the last stage forms a lane result
   typedef enum logic [1:0] {
      KIND_QUOT,      // round(n/255)
      KIND_QUOT_INV,  // 255 - round(n/255)
      KIND_SCALE,     // rounded, saturated gain product
      KIND_PASS       // value settled in the first stage
   } lane_kind_type;

   // Per-stage load enables, driven by the pipeline control in the top level
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stg_en_type;

   localparam logic [PIX_W-1:0] PIX_MAX = '1;

endpackage

[hw/rtl/rpb_if.sv]
// Valid/ready channel interfaces for the RGB pixel blend unit.
// Depends on rpb_pkg for field widths.
interface rpb_req_if import rpb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] top_red;
   logic [PIX_W-1:0] top_green;
   logic [PIX_W-1:0] top_blue;
   logic [PIX_W-1:0] bottom_red;
   logic [PIX_W-1:0] bottom_green;
   logic [PIX_W-1:0] bottom_blue;

   modport source (output valid, top_red, top_green, top_blue,
                   bottom_red, bottom_green, bottom_blue, input ready);
   modport sink   (input valid, top_red, top_green, top_blue,
                   bottom_red, bottom_green, bottom_blue, output ready);
endinterface

interface rpb_rsp_if import rpb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_red;
   logic [PIX_W-1:0] out_green;
   logic [PIX_W-1:0] out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface rpb_csr_if import rpb_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/rpb_lane.sv]
// One color channel of the blend datapath: four register stages.
// Depends on rpb_pkg; stage enables come from the top level.
module rpb_lane import rpb_pkg::*; (
   input  logic              clock,
   input  stg_en_type        stg_en,
   input  blend_mode_type    mode,
   input  logic [GAIN_W-1:0] gain,
   input  logic [PIX_W-1:0]  top,
   input  logic [PIX_W-1:0]  bottom,
   output logic [PIX_W-1:0]  result
);

   // Stage 1: operand select, add/subtract
   logic [PIX_W-1:0]  x1_in, x1_ff;
   logic [GAIN_W-1:0] y1_in, y1_ff;
   logic              dbl1_in, dbl1_ff;
   lane_kind_type     kind1_in, kind1_ff;
   logic [PIX_W-1:0]  pass1_in, pass1_ff;
   logic [PIX_W:0]    addsum;

   // Stage 2: product
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] n2_in, n2_ff;
   lane_kind_type     kind2_ff;
   logic [PIX_W-1:0]  pass2_ff;

   // Stage 3: quotient estimate, scale rounding
   logic [DIVM_W-1:0] m3_in, m3_ff;
   logic [DIVM_W-1:0] mq_sum;
   logic [QEST_W-1:0] q3_in, q3_ff;
   logic [SUM_W-1:0]  scale_sum;
   logic [SUM_W-1:0]  scale_sh;
   logic [PIX_W-1:0]  pass3_in, pass3_ff;
   lane_kind_type     kind3_ff;

   // Stage 4: quotient correction and final form
   logic [DIVM_W-1:0] rem;
   logic [QEST_W-1:0] q4;
   logic [PIX_W-1:0]  out_in, out_ff;

   always_comb begin
      addsum   = {1'b0, bottom} + {1'b0, top};
      x1_in    = bottom;
      y1_in    = GAIN_W'(top);
      dbl1_in  = 1'b0;
      kind1_in = KIND_PASS;
      pass1_in = bottom;
      case (mode)
         MODE_MULTIPLY: begin
            kind1_in = KIND_QUOT;
         end
         MODE_SCREEN: begin
            x1_in    = ~bottom;
            y1_in    = GAIN_W'(PIX_MAX - top);
            kind1_in = KIND_QUOT_INV;
         end
         MODE_OVERLAY: begin
            dbl1_in = 1'b1;
            if (bottom[PIX_W-1]) begin
               x1_in    = ~bottom;
               y1_in    = GAIN_W'(PIX_MAX - top);
               kind1_in = KIND_QUOT_INV;
            end else begin
               kind1_in = KIND_QUOT;
            end
         end
         MODE_SUBTRACT: begin
            pass1_in = (bottom >= top) ? (bottom - top) : '0;
         end
         MODE_ADD: begin
            pass1_in = addsum[PIX_W] ? PIX_MAX : addsum[PIX_W-1:0];
         end
         MODE_SCALE: begin
            y1_in    = gain;
            kind1_in = KIND_SCALE;
         end
         default: begin
            pass1_in = bottom;   // unused modes pass the bottom pixel
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stg_en.s1) begin
         x1_ff    <= x1_in;
         y1_ff    <= y1_in;
         dbl1_ff  <= dbl1_in;
         kind1_ff <= kind1_in;
         pass1_ff <= pass1_in;
      end
   end

   assign prod  = PROD_W'(x1_ff) * PROD_W'(y1_ff);
   assign n2_in = dbl1_ff ? {prod[PROD_W-2:0], 1'b0} : prod;

   always_ff @(posedge clock) begin
      if (stg_en.s2) begin
         n2_ff    <= n2_in;
         kind2_ff <= kind1_ff;
         pass2_ff <= pass1_ff;
      end
   end

   // floor((n+127)/255) estimated as (m + m/256)/256; at most one low
   assign m3_in  = DIVM_W'(n2_ff[QIN_W-1:0]) + DIVM_W'(127);
   assign mq_sum = m3_in + (m3_in >> PIX_W);
   assign q3_in  = mq_sum[DIVM_W-1:PIX_W];

   assign scale_sum = SUM_W'(n2_ff) + SUM_W'(SCALE_HALF);
   assign scale_sh  = scale_sum >> GAIN_FRAC_BITS;

   always_comb begin
      pass3_in = pass2_ff;
      if (kind2_ff == KIND_SCALE) begin
         pass3_in = (|scale_sh[SUM_W-1:PIX_W]) ? PIX_MAX : scale_sh[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stg_en.s3) begin
         m3_ff    <= m3_in;
         q3_ff    <= q3_in;
         pass3_ff <= pass3_in;
         kind3_ff <= kind2_ff;
      end
   end

   // remainder = m - 255*q
   assign rem = m3_ff - {q3_ff, {PIX_W{1'b0}}} + DIVM_W'(q3_ff);
   assign q4  = q3_ff + QEST_W'(rem >= DIVM_W'(255));

   always_comb begin
      case (kind3_ff)
         KIND_QUOT:     out_in = q4[PIX_W-1:0];
         KIND_QUOT_INV: out_in = ~q4[PIX_W-1:0];
         default:       out_in = pass3_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stg_en.s4) begin
         out_ff <= out_in;
      end
   end

   assign result = out_ff;

endmodule

[hw/rtl/rgb_pixel_blend_unit.sv]
// Top level of the RGB pixel blend unit: config registers, pipeline
// control and three channel lanes. Depends on rpb_pkg, rpb_if, rpb_lane.
//
// Usage
//   req_bus : one top and one bottom RGB pixel per transfer.
//   rsp_bus : one blended RGB pixel per request, in request order.
//   csr_bus : register writes (0 blend_mode, 1..3 gain_red/green/blue,
//             unsigned 8.8). Always ready; writes beyond index 3 are dropped.
//             Write only while no pixel is in flight.
//   Modes: multiply, screen, overlay, subtract, add, scale (gain, saturating).
//   Modes 6 and 7 return the bottom pixel.
//
// Timing
//   Four register stages: operand select, multiply, divide-by-255 estimate,
//   correction. A result is registered in each stage in turn before it is
//   presented on rsp_bus. One pixel per clock sustained while rsp_bus accepts;
//   the multiplier per lane sets the stage split.
//   When rsp_bus stalls, stages fill from the output backward; req_bus.ready
//   drops only once every stage holds a pixel. Nothing is dropped or repeated.
//   Reset (synchronous) empties the pipeline and restores mode 0 (multiply)
//   and unity gains.
module rgb_pixel_blend_unit import rpb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rpb_req_if.sink    req_bus,
   rpb_rsp_if.source  rsp_bus,
   rpb_csr_if.sink    csr_bus
);

   // ---------------- configuration registers ----------------
   blend_mode_type    mode_ff;
   logic [GAIN_W-1:0] gain_red_ff;
   logic [GAIN_W-1:0] gain_green_ff;
   logic [GAIN_W-1:0] gain_blue_ff;
   logic              csr_xfer;

   assign csr_bus.ready = 1'b1;
   assign csr_xfer      = csr_bus.valid && csr_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_MULTIPLY;
         gain_red_ff   <= GAIN_W'(1 << GAIN_FRAC_BITS);
         gain_green_ff <= GAIN_W'(1 << GAIN_FRAC_BITS);
         gain_blue_ff  <= GAIN_W'(1 << GAIN_FRAC_BITS);
      end else if (csr_xfer) begin
         case (csr_bus.index)
            CSR_BLEND_MODE: mode_ff       <= blend_mode_type'(csr_bus.data[2:0]);
            CSR_GAIN_RED:   gain_red_ff   <= csr_bus.data[GAIN_W-1:0];
            CSR_GAIN_GREEN: gain_green_ff <= csr_bus.data[GAIN_W-1:0];
            CSR_GAIN_BLUE:  gain_blue_ff  <= csr_bus.data[GAIN_W-1:0];
            default: ;  // out-of-range index: ignored
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   // A stage loads when it is empty or the stage after it loads.
   logic       v1_ff, v2_ff, v3_ff, v4_ff;
   stg_en_type stg_en;

   assign stg_en.s4 = !v4_ff || rsp_bus.ready;
   assign stg_en.s3 = !v3_ff || stg_en.s4;
   assign stg_en.s2 = !v2_ff || stg_en.s3;
   assign stg_en.s1 = !v1_ff || stg_en.s2;

   assign req_bus.ready = stg_en.s1;
   assign rsp_bus.valid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (stg_en.s1) v1_ff <= req_bus.valid;
         if (stg_en.s2) v2_ff <= v1_ff;
         if (stg_en.s3) v3_ff <= v2_ff;
         if (stg_en.s4) v4_ff <= v3_ff;
      end
   end

   // ---------------- channel lanes ----------------
   rpb_lane u_lane_red (
      .clock  (clock),
      .stg_en (stg_en),
      .mode   (mode_ff),
      .gain   (gain_red_ff),
      .top    (req_bus.top_red),
      .bottom (req_bus.bottom_red),
      .result (rsp_bus.out_red)
   );

   rpb_lane u_lane_green (
      .clock  (clock),
      .stg_en (stg_en),
      .mode   (mode_ff),
      .gain   (gain_green_ff),
      .top    (req_bus.top_green),
      .bottom (req_bus.bottom_green),
      .result (rsp_bus.out_green)
   );

   rpb_lane u_lane_blue (
      .clock  (clock),
      .stg_en (stg_en),
      .mode   (mode_ff),
      .gain   (gain_blue_ff),
      .top    (req_bus.top_blue),
      .bottom (req_bus.bottom_blue),
      .result (rsp_bus.out_blue)
   );

   // ---------------- assertions ----------------
   // Input backpressure only when every stage is occupied and output stalls.
   a_ready_when_room: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_bus.ready))
      else $error("req stalled while pipeline has room");

   // A pixel in stage 1 moving on must appear in stage 2.
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && stg_en.s2) |=> v2_ff)
      else $error("pixel lost between stage 1 and 2");

   // Gain write lands in the register.
   a_gain_write: assert property (@(posedge clock) disable iff (reset)
      (csr_xfer && csr_bus.index == CSR_GAIN_RED) |=>
      (gain_red_ff == $past(csr_bus.data[GAIN_W-1:0])))
      else $error("gain_red write not taken");

   // Reset empties the output stage.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("rsp valid after reset");

endmodule
